FILE: rtl/mavlink2_frame_packer_top_defines.svh
// assertion macros for the mavlink 2 frame packer top level
// expects clk and rst_n in the scope that uses them
`ifndef MAVLINK2_FRAME_PACKER_TOP_DEFINES_SVH
`define MAVLINK2_FRAME_PACKER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mfp_pkg.sv
// shared types, constants and the x25 crc step for the mavlink 2 frame packer
// no dependencies
package mfp_pkg;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        first_byte;
    logic        last_byte;
    logic [7:0]  payload_length;
    logic [23:0] message_id;
    logic [7:0]  crc_extra;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
  } out_word_t;

  localparam int STEP_W = 4;

  // position of a byte within one item's output run
  localparam logic [STEP_W-1:0] STEP_START   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LEN     = 4'd1;
  localparam logic [STEP_W-1:0] STEP_INCOMPAT = 4'd2;
  localparam logic [STEP_W-1:0] STEP_COMPAT  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SEQ     = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SYS     = 4'd5;
  localparam logic [STEP_W-1:0] STEP_COMP    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_MID0    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_MID1    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_MID2    = 4'd9;
  localparam logic [STEP_W-1:0] STEP_PAYLOAD = 4'd10;
  localparam logic [STEP_W-1:0] STEP_CRC_LO  = 4'd11;
  localparam logic [STEP_W-1:0] STEP_CRC_HI  = 4'd12;

  localparam logic [7:0]  START_MARK = 8'hFD;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [7:0]  FLAGS_ZERO = 8'h00;

  localparam int unsigned REG_SYS_ID  = 0;
  localparam int unsigned REG_COMP_ID = 1;
  localparam logic [7:0]  SYS_ID_RST  = 8'd1;
  localparam logic [7:0]  COMP_ID_RST = 8'd1;

  typedef struct packed {
    logic              in_frame;
    logic              load;
    logic [STEP_W-1:0] pos;
  } fr_status_t;

  // one byte into the reflected x25 crc (poly 0x1021)
  function automatic logic [15:0] x25_step(input logic [15:0] crc, input logic [7:0] data);
    logic [7:0] t;
    t = data ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

FILE: rtl/mavlink2_frame_packer_top.sv
// channel     dir  handshake               payload
// in_         in   in_valid / in_stall     mfp_pkg::in_word_t
// out_        out  out_valid / out_stall   mfp_pkg::out_word_t
// config      in   apb psel/penable/pwrite 2 regs at 0x0, 0x4
//
// one output byte per cycle while out_stall is low; a first word yields 11 or 13 bytes, later words 1 or 3,
// so the rate is set by the output byte register, one word per cycle for plain payload
// bytes. a word is held in the input register while its bytes go out, and the next word
// is taken in the cycle its last byte loads. dropped words (no open frame) are taken without output.
// rst_n is synchronous; it clears control state, ids return to 1, sequence to 0.
// out_stall holds the output register; the input register stalls behind it.
// depends on mfp_pkg, mfp_in_reg, mfp_framer and the defines header
`include "mavlink2_frame_packer_top_defines.svh"

module mavlink2_frame_packer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mfp_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mfp_pkg::out_word_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0]          sys_id_r, sys_id_nxt;
  logic [7:0]          comp_id_r, comp_id_nxt;
  logic                wr_en;
  logic                reg_idx;
  logic                cur_vld;
  mfp_pkg::in_word_t   cur_data;
  logic                take;
  mfp_pkg::fr_status_t status;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    sys_id_nxt  = sys_id_r;
    comp_id_nxt = comp_id_r;
    if (wr_en) begin
      if (reg_idx == 1'(mfp_pkg::REG_SYS_ID)) begin
        sys_id_nxt = pwdata[7:0];
      end else begin
        comp_id_nxt = pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_id_r  <= mfp_pkg::SYS_ID_RST;
      comp_id_r <= mfp_pkg::COMP_ID_RST;
    end else begin
      sys_id_r  <= sys_id_nxt;
      comp_id_r <= comp_id_nxt;
    end
  end

  always_comb begin
    prdata = 32'h0;
    if (reg_idx == 1'(mfp_pkg::REG_COMP_ID)) begin
      prdata = {24'h0, comp_id_r};
    end else begin
      prdata = {24'h0, sys_id_r};
    end
  end

  mfp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take     (take),
    .cur_vld  (cur_vld),
    .cur_data (cur_data)
  );

  mfp_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cur_vld   (cur_vld),
    .cur_data  (cur_data),
    .sys_id    (sys_id_r),
    .comp_id   (comp_id_r),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (status)
  );

  // a packet always ends on the last byte of its word
  `MFP_ASSERT_NOW(a_end_is_run_last, out_valid && out_data.frame_end, out_data.run_last, "frame_end without run_last")
  // loading the high crc byte closes the frame
  `MFP_ASSERT_NEXT(a_crc_hi_closes, status.load && (status.pos == mfp_pkg::STEP_CRC_HI), !status.in_frame, "frame still open after crc")
  // the byte position never runs past the high crc byte
  `MFP_ASSERT_NOW(a_pos_bound, status.load, status.pos <= mfp_pkg::STEP_CRC_HI, "byte position out of range")

endmodule

FILE: rtl/mfp_in_reg.sv
// input holding register for the frame packer
// uses mfp_pkg::in_word_t
module mfp_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  mfp_pkg::in_word_t in_data,
  input  logic            take,
  output logic            cur_vld,
  output mfp_pkg::in_word_t cur_data
);

  logic              vld_r;
  logic              vld_nxt;
  mfp_pkg::in_word_t data_r;
  logic              accept;

  // the held word may leave and a new one enter in the same cycle
  assign in_stall = vld_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_data;
    end
  end

  assign cur_vld  = vld_r;
  assign cur_data = data_r;

endmodule

FILE: rtl/mfp_framer.sv
// byte sequencer: header, payload and crc bytes into the output register
// uses mfp_pkg types, step codes and x25_step
module mfp_framer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cur_vld,
  input  mfp_pkg::in_word_t  cur_data,
  input  logic [7:0]         sys_id,
  input  logic [7:0]         comp_id,
  output logic               take,
  output logic               out_valid,
  input  logic               out_stall,
  output mfp_pkg::out_word_t out_data,
  output mfp_pkg::fr_status_t status
);

  logic [mfp_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]                crc_r, crc_nxt;
  logic [7:0]                 extra_r, extra_nxt;
  logic [7:0]                 seq_r, seq_nxt;
  logic                       in_frame_r, in_frame_nxt;
  logic                       out_vld_r, out_vld_nxt;
  mfp_pkg::out_word_t         out_r;

  logic                       active;
  logic                       out_free;
  logic                       load;
  logic [mfp_pkg::STEP_W-1:0] pos;
  logic [mfp_pkg::STEP_W-1:0] last_pos;
  logic [15:0]                fin;
  logic [7:0]                 byte_sel;
  logic                       hashed;

  // a non-first word outside a frame is dropped without output
  assign active   = cur_vld && (cur_data.first_byte || in_frame_r);
  assign out_free = !out_vld_r || !out_stall;
  assign load     = active && out_free;
  assign pos      = cur_data.first_byte ? cnt_r : cnt_r + mfp_pkg::STEP_PAYLOAD;
  assign last_pos = cur_data.last_byte ? mfp_pkg::STEP_CRC_HI : mfp_pkg::STEP_PAYLOAD;
  assign fin      = mfp_pkg::x25_step(crc_r, extra_r);

  always_comb begin
    hashed = 1'b1;
    unique case (pos)
      mfp_pkg::STEP_START: begin
        byte_sel = mfp_pkg::START_MARK;
        hashed   = 1'b0;
      end
      mfp_pkg::STEP_LEN:      byte_sel = cur_data.payload_length;
      mfp_pkg::STEP_INCOMPAT: byte_sel = mfp_pkg::FLAGS_ZERO;
      mfp_pkg::STEP_COMPAT:   byte_sel = mfp_pkg::FLAGS_ZERO;
      mfp_pkg::STEP_SEQ:      byte_sel = seq_r;
      mfp_pkg::STEP_SYS:      byte_sel = sys_id;
      mfp_pkg::STEP_COMP:     byte_sel = comp_id;
      mfp_pkg::STEP_MID0:     byte_sel = cur_data.message_id[7:0];
      mfp_pkg::STEP_MID1:     byte_sel = cur_data.message_id[15:8];
      mfp_pkg::STEP_MID2:     byte_sel = cur_data.message_id[23:16];
      mfp_pkg::STEP_PAYLOAD:  byte_sel = cur_data.payload_byte;
      mfp_pkg::STEP_CRC_LO: begin
        byte_sel = fin[7:0];
        hashed   = 1'b0;
      end
      mfp_pkg::STEP_CRC_HI: begin
        // crc_r already holds the finished checksum here
        byte_sel = crc_r[15:8];
        hashed   = 1'b0;
      end
      default: begin
        byte_sel = 8'h00;
        hashed   = 1'b0;
      end
    endcase
  end

  always_comb begin
    crc_nxt      = crc_r;
    extra_nxt    = extra_r;
    seq_nxt      = seq_r;
    in_frame_nxt = in_frame_r;
    if (load) begin
      if (hashed) begin
        crc_nxt = mfp_pkg::x25_step(crc_r, byte_sel);
      end
      if (pos == mfp_pkg::STEP_START) begin
        crc_nxt      = mfp_pkg::CRC_INIT;
        extra_nxt    = cur_data.crc_extra;
        in_frame_nxt = 1'b1;
      end
      if (pos == mfp_pkg::STEP_SEQ) begin
        seq_nxt = seq_r + 8'd1;
      end
      if (pos == mfp_pkg::STEP_CRC_LO) begin
        crc_nxt = fin;
      end
      if (pos == mfp_pkg::STEP_CRC_HI) begin
        crc_nxt      = mfp_pkg::CRC_INIT;
        in_frame_nxt = 1'b0;
      end
    end
  end

  assign take = (load && (pos == last_pos)) || (cur_vld && !active);

  always_comb begin
    cnt_nxt = cnt_r;
    if (take) begin
      cnt_nxt = '0;
    end else if (load) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_free) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      crc_r      <= mfp_pkg::CRC_INIT;
      extra_r    <= 8'h00;
      seq_r      <= 8'h00;
      in_frame_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      crc_r      <= crc_nxt;
      extra_r    <= extra_nxt;
      seq_r      <= seq_nxt;
      in_frame_r <= in_frame_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.out_byte  <= byte_sel;
      out_r.frame_end <= (pos == mfp_pkg::STEP_CRC_HI);
      out_r.run_last  <= (pos == last_pos);
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign status.in_frame = in_frame_r;
  assign status.load     = load;
  assign status.pos      = pos;

endmodule

FILE: test/tb_mavlink2_frame_packer_top.sv
// testbench for mavlink2_frame_packer_top: predicts each framed byte with its own x25 crc
// and compares every output word with it; random sender bursts and receiver stalls
// depends on mfp_pkg and the frame packer rtl
module tb_mavlink2_frame_packer_top;

  localparam logic [15:0] X25_POLY_REV  = 16'h8408;  // 0x1021 bit-reversed
  localparam logic [7:0]  HEARTBEAT_EXTRA = 8'd50;
  localparam logic [7:0]  VISION_EXTRA    = 8'h8C;
  localparam logic [7:0]  HIGHRES_EXTRA   = 8'h96;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  mfp_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_stall = 1'b0;
  mfp_pkg::out_word_t out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  mavlink2_frame_packer_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 400000);
    $display("tb_mavlink2_frame_packer_top failed");
    $finish;
  end

  // predicted link bytes and the framer state behind them
  mfp_pkg::out_word_t expected_bytes[$];
  mfp_pkg::out_word_t head_word;
  logic [7:0]  seq_num = 8'd0;
  logic [15:0] crc_acc = mfp_pkg::CRC_INIT;
  logic [7:0]  extra_held = 8'd0;
  logic        frame_open = 1'b0;
  logic [7:0]  sys_id_sh = mfp_pkg::SYS_ID_RST;
  logic [7:0]  comp_id_sh = mfp_pkg::COMP_ID_RST;
  int unsigned mismatch_count = 0;

  // stimulus bookkeeping
  int  words_sent = 0;
  int  burst_left = 0;
  bit  gen_open = 1'b0;
  int  hold_reqs = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  int  pat_cnt = 0;

  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] d);
    logic [15:0] c;
    int i;
    c = crc ^ {8'h00, d};
    for (i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ X25_POLY_REV) : (c >> 1);
    return c;
  endfunction

  function automatic void push_byte(logic [7:0] b, logic hashed, logic ends);
    mfp_pkg::out_word_t r;
    if (hashed) crc_acc = crc_fold(crc_acc, b);
    r.out_byte = b;
    r.frame_end = ends;
    r.run_last = 1'b0;
    expected_bytes.push_back(r);
  endfunction

  function automatic void predict_link_bytes(mfp_pkg::in_word_t w);
    logic [15:0] fin;
    if (w.first_byte) begin
      crc_acc = mfp_pkg::CRC_INIT;
      extra_held = w.crc_extra;
      frame_open = 1'b1;
      push_byte(mfp_pkg::START_MARK, 1'b0, 1'b0);
      push_byte(w.payload_length, 1'b1, 1'b0);
      push_byte(mfp_pkg::FLAGS_ZERO, 1'b1, 1'b0);
      push_byte(mfp_pkg::FLAGS_ZERO, 1'b1, 1'b0);
      push_byte(seq_num, 1'b1, 1'b0);
      seq_num = seq_num + 8'd1;
      push_byte(sys_id_sh, 1'b1, 1'b0);
      push_byte(comp_id_sh, 1'b1, 1'b0);
      push_byte(w.message_id[7:0], 1'b1, 1'b0);
      push_byte(w.message_id[15:8], 1'b1, 1'b0);
      push_byte(w.message_id[23:16], 1'b1, 1'b0);
    end else if (!frame_open) begin
      return;  // no open frame: word is dropped
    end
    push_byte(w.payload_byte, 1'b1, 1'b0);
    if (w.last_byte) begin
      fin = crc_fold(crc_acc, extra_held);
      push_byte(fin[7:0], 1'b0, 1'b0);
      push_byte(fin[15:8], 1'b0, 1'b1);
      crc_acc = mfp_pkg::CRC_INIT;
      frame_open = 1'b0;
    end
    expected_bytes[expected_bytes.size() - 1].run_last = 1'b1;
  endfunction

  // predict on accepted input words, check accepted output words
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) predict_link_bytes(in_data);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected output word: out_byte %02h", out_data.out_byte);
        mismatch_count++;
      end else begin
        head_word = expected_bytes.pop_front();
        if (out_data.out_byte !== head_word.out_byte) begin
          $error("out_byte expected %02h got %02h", head_word.out_byte, out_data.out_byte);
          mismatch_count++;
        end
        if (out_data.frame_end !== head_word.frame_end) begin
          $error("frame_end expected %0b got %0b", head_word.frame_end, out_data.frame_end);
          mismatch_count++;
        end
        if (out_data.run_last !== head_word.run_last) begin
          $error("run_last expected %0b got %0b", head_word.run_last, out_data.run_last);
          mismatch_count++;
        end
      end
    end
  end

  // receiver: rotating stall pattern, plus long holds on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_served != hold_reqs) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      pat_cnt++;
      case (stall_mode_t'((pat_cnt / 97) % 4))
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
        default:     out_stall <= (pat_cnt % 3 == 0);
      endcase
    end
  end

  task automatic send_word(input mfp_pkg::in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    // let the last accepted word be predicted before the queue is checked
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write, then read back the same register
  task automatic write_reg(input int unsigned idx, input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(idx * 4);
    pwdata <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'h0, val}) begin
      $error("prdata expected %08h got %08h", {24'h0, val}, prdata);
      mismatch_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_ids(input logic [7:0] sys, input logic [7:0] comp);
    wait_drained();
    write_reg(mfp_pkg::REG_SYS_ID, sys);
    sys_id_sh = sys;
    write_reg(mfp_pkg::REG_COMP_ID, comp);
    comp_id_sh = comp;
  endtask

  function automatic mfp_pkg::in_word_t word_of(logic [7:0] pb, logic first, logic last,
                                                logic [7:0] plen, logic [23:0] mid,
                                                logic [7:0] extra);
    mfp_pkg::in_word_t w;
    w.payload_byte = pb;
    w.first_byte = first;
    w.last_byte = last;
    w.payload_length = plen;
    w.message_id = mid;
    w.crc_extra = extra;
    return w;
  endfunction

  function automatic mfp_pkg::in_word_t random_word();
    return mfp_pkg::in_word_t'(50'({$urandom, $urandom}));
  endfunction

  function automatic logic [7:0] pick_extra();
    case ($urandom_range(0, 5))
      0: return HEARTBEAT_EXTRA;
      1: return VISION_EXTRA;
      2: return HIGHRES_EXTRA;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int random_frame_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 1;
    if (r < 9) return $urandom_range(2, 6);
    return $urandom_range(7, 48);
  endfunction

  // well-formed frame with random content; an unfinished one leaves the frame open
  task automatic send_frame(input int n, input bit complete);
    mfp_pkg::in_word_t w;
    int k;
    for (k = 0; k < n; k++) begin
      w = random_word();
      w.first_byte = (k == 0);
      w.last_byte = complete && (k == n - 1);
      if (k == 0) begin
        if ($urandom_range(0, 4) != 0) w.payload_length = n[7:0];
        w.crc_extra = pick_extra();
      end
      send_word(w);
      words_sent++;
    end
    gen_open = !complete;
  endtask

  task automatic send_noise();
    mfp_pkg::in_word_t w;
    bit counted;
    w = random_word();
    w.first_byte = ($urandom_range(0, 3) == 0);
    counted = w.first_byte || gen_open;
    if (counted && w.last_byte) gen_open = 1'b0;
    else if (w.first_byte) gen_open = 1'b1;
    send_word(w);
    if (counted) words_sent++;
  endtask

  task automatic run_traffic(input int target);
    int start;
    int r;
    start = words_sent;
    while (words_sent - start < target) begin
      r = $urandom_range(0, 19);
      if (r < 15) send_frame(random_frame_len(), 1'b1);
      else if (r < 17) send_frame(random_frame_len(), 1'b0);
      else repeat ($urandom_range(1, 3)) send_noise();
    end
  endtask

  task automatic test_reset_ids();
    send_word(word_of(8'h00, 1'b1, 1'b1, 8'd1, 24'h000000, HEARTBEAT_EXTRA));
    wait_drained();
  endtask

  task automatic test_field_extremes();
    send_word(word_of(8'hFF, 1'b1, 1'b0, 8'd255, 24'hFFFFFF, VISION_EXTRA));
    send_word(word_of(8'h00, 1'b0, 1'b0, 8'h00, 24'h000000, 8'h00));
    send_word(word_of(8'hFF, 1'b0, 1'b1, 8'hFF, 24'hFFFFFF, 8'hFF));
    // header length 0 against two payload bytes
    send_word(word_of(8'hA5, 1'b1, 1'b0, 8'd0, 24'h000001, HIGHRES_EXTRA));
    send_word(word_of(8'h5A, 1'b0, 1'b1, 8'd0, 24'h800000, 8'h00));
    send_word(word_of(8'h80, 1'b1, 1'b1, 8'd1, 24'h123456, 8'hFF));
    wait_drained();
  endtask

  task automatic test_idle_bytes();
    send_word(word_of(8'h11, 1'b0, 1'b0, 8'd3, 24'hABCDEF, 8'h33));
    send_word(word_of(8'h22, 1'b0, 1'b1, 8'd7, 24'h010203, 8'h44));
    send_word(random_word() & ~mfp_pkg::in_word_t'({8'h00, 1'b1, 41'h0}));
    wait_drained();
  endtask

  task automatic test_restart();
    send_word(word_of(8'h31, 1'b1, 1'b0, 8'd4, 24'h00004C, VISION_EXTRA));
    send_word(word_of(8'h32, 1'b0, 1'b0, 8'd4, 24'h00004C, VISION_EXTRA));
    // new frame while the previous one is still open
    send_word(word_of(8'h41, 1'b1, 1'b0, 8'd2, 24'h000069, HIGHRES_EXTRA));
    send_word(word_of(8'h42, 1'b0, 1'b1, 8'd2, 24'h000069, HIGHRES_EXTRA));
    send_word(word_of(8'h51, 1'b1, 1'b0, 8'd9, 24'h0000FE, HEARTBEAT_EXTRA));
    send_word(word_of(8'h52, 1'b1, 1'b1, 8'd1, 24'h000000, HEARTBEAT_EXTRA));
    gen_open = 1'b0;
    wait_drained();
  endtask

  task automatic test_sequence_wrap();
    repeat (260) send_frame(1, 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_reqs++;
    run_traffic(60);
    wait_drained();
  endtask

  task automatic test_random_mix();
    run_traffic(130);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_ids();
    test_field_extremes();
    test_idle_bytes();
    test_restart();
    set_ids(8'h00, 8'h00);
    test_sequence_wrap();
    set_ids(8'hFF, 8'hFF);
    test_backpressure();
    set_ids(8'($urandom), 8'($urandom));
    test_random_mix();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("tb_mavlink2_frame_packer_top passed");
    end else begin
      $display("tb_mavlink2_frame_packer_top failed");
    end
    $finish;
  end

endmodule
